### rtl/wsp_pkg.sv
package wsp_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [31:0] ID_FMT  = 32'h20746D66;
    localparam logic [31:0] ID_DATA = 32'h61746164;
    localparam logic [31:0] RECIP3  = 32'hAAAAAAAB;

    // smallest byte count after the stereo halving that is rejected as too long, per sample width
    localparam logic [31:0] LIMIT_NARROW = 32'h0200_0000;
    localparam logic [31:0] LIMIT_WIDE   = 32'h0300_0000;

    localparam logic [1:0] KIND_REPORT = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_COMPRESSED = 3'd1;
    localparam logic [2:0] ERR_CHANNELS   = 3'd2;
    localparam logic [2:0] ERR_BITS       = 3'd3;
    localparam logic [2:0] ERR_MULTIPLE   = 3'd4;
    localparam logic [2:0] ERR_TOO_LONG   = 3'd5;
    localparam logic [2:0] ERR_TRUNCATED  = 3'd6;
    localparam logic [2:0] ERR_SHORT_FMT  = 3'd7;

    typedef enum logic [3:0] {
        PH_HEADER     = 4'd0,
        PH_CHUNK_ID   = 4'd1,
        PH_CHUNK_SIZE = 4'd2,
        PH_CHUNK_SKIP = 4'd3,
        PH_FMT_SIZE   = 4'd4,
        PH_FMT_TAG    = 4'd5,
        PH_FMT_CHAN   = 4'd6,
        PH_FMT_RATE   = 4'd7,
        PH_FMT_MISC   = 4'd8,
        PH_FMT_BITS   = 4'd9,
        PH_FMT_EXTRA  = 4'd10,
        PH_DATA_ID    = 4'd11,
        PH_DATA_SIZE  = 4'd12,
        PH_DATA_SKIP  = 4'd13,
        PH_SAMPLES    = 4'd14,
        PH_HALTED     = 4'd15
    } phase_t;

    // one classified event from the parser
    // report: word_a = rate, word_b = data bytes (halved for stereo)
    // sample: word_a = left or mono sample, word_b = right or mono sample
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  error_code;
        logic        last;
        logic        stereo;
        logic        wide;
        logic [31:0] word_a;
        logic [31:0] word_b;
    } wsp_event_t;

    // running remainder mod 3 of a little-endian number, one byte at a time
    function automatic logic [1:0] mod3_add(input logic [1:0] acc, input logic [7:0] b);
        logic [3:0] s;
        logic [2:0] f;
        logic [2:0] g;
        s = {2'b0, acc} + {2'b0, b[7:6]} + {2'b0, b[5:4]} + {2'b0, b[3:2]}
            + {2'b0, b[1:0]};
        f = {1'b0, s[3:2]} + {1'b0, s[1:0]};
        g = {2'b0, f[2]} + {1'b0, f[1:0]};
        return (g == 3'd3) ? 2'd0 : g[1:0];
    endfunction

    function automatic logic [7:0] mulaw_code(input logic [15:0] a);
        logic        neg;
        logic [15:0] mag;
        logic [15:0] biased;
        logic [14:0] clip;
        logic [2:0]  seg;
        logic [14:0] sh;
        neg = a[15];
        mag = neg ? (16'd0 - a) : a;
        biased = mag + 16'd128;
        clip = (biased > 16'h7FFF) ? 15'h7FFF : biased[14:0];
        seg = 3'd0;
        for (int i = 1; i < 8; i++) begin
            if (clip >= (15'h80 << i)) seg = 3'(i);
        end
        sh = clip >> ({1'b0, seg} + 4'd3);
        return {neg, seg, sh[3:0]};
    endfunction

endpackage

### rtl/wsp_parse.sv
module wsp_parse (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                byte_valid,
    output logic                byte_ready,
    input  logic [7:0]          file_byte,
    input  logic                end_of_file,
    output logic                ev_push,
    output wsp_pkg::wsp_event_t ev,
    input  logic                queue_full
);
    import wsp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [2:0]  pos_reg, pos_next;
    logic [31:0] gather_reg, gather_next;
    logic [31:0] skip_reg, skip_next;
    logic [15:0] tag_reg, tag_next;
    logic        stereo_reg, stereo_next;
    logic        wide_reg, wide_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] left_reg, left_next;
    logic [1:0]  mod3_reg, mod3_next;

    logic        accept;
    logic        emit;
    logic        last4;
    logic [2:0]  pos_inc;
    logic [31:0] skip_shift;
    logic [31:0] skip_dec;
    logic [31:0] halved;
    logic [1:0]  mod3_sum;
    logic        mod_bad;
    logic        too_long;
    logic [2:0]  chan_bytes;
    logic        second;
    logic [2:0]  q;
    logic [15:0] s;
    logic [15:0] chans;
    logic [15:0] bits;

    assign byte_ready = !queue_full;
    assign accept     = byte_valid && byte_ready;
    assign ev_push    = accept && emit;

    assign last4      = (pos_reg == 3'd3);
    assign pos_inc    = pos_reg + 3'd1;
    assign skip_shift = {file_byte, skip_reg[31:8]};
    assign skip_dec   = skip_reg - 32'd1;
    assign halved     = stereo_reg ? {1'b0, skip_shift[31:1]} : skip_shift;
    assign mod3_sum   = mod3_add((pos_reg == 3'd0) ? 2'd0 : mod3_reg, file_byte);
    assign chan_bytes = wide_reg ? 3'd3 : 3'd2;
    assign second     = (pos_reg >= chan_bytes);
    assign q          = second ? (pos_reg - chan_bytes) : pos_reg;
    assign s          = {file_byte, gather_reg[7:0]};
    // taken on the second bits byte
    assign chans      = gather_reg[15:0];
    assign bits       = {file_byte, gather_reg[23:16]};

    // whole frames only; 16-bit mono even, 16-bit stereo multiple of 4, 24-bit multiple of 3, stereo 24-bit also even
    always_comb begin
        if (wide_reg) begin
            mod_bad = (stereo_reg && skip_shift[0]) || (mod3_sum != 2'd0);
        end else if (stereo_reg) begin
            mod_bad = (skip_shift[1:0] != 2'd0);
        end else begin
            mod_bad = skip_shift[0];
        end
        too_long = wide_reg ? (halved >= LIMIT_WIDE) : (halved >= LIMIT_NARROW);
    end

    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        gather_next = gather_reg;
        skip_next   = skip_reg;
        tag_next    = tag_reg;
        stereo_next = stereo_reg;
        wide_next   = wide_reg;
        rate_next   = rate_reg;
        left_next   = left_reg;
        mod3_next   = mod3_reg;
        emit        = 1'b0;
        ev          = '0;

        case (phase_reg)
            PH_HEADER: begin
                skip_next = skip_reg + 32'd1;
                if (skip_next >= 32'd12) begin
                    skip_next  = '0;
                    phase_next = PH_CHUNK_ID;
                end
            end
            PH_CHUNK_ID, PH_DATA_ID: begin
                gather_next = {file_byte, gather_reg[31:8]};
                pos_next    = pos_inc;
                if (last4) begin
                    pos_next = '0;
                    if (phase_reg == PH_CHUNK_ID) begin
                        phase_next = (gather_next == ID_FMT) ? PH_FMT_SIZE : PH_CHUNK_SIZE;
                    end else begin
                        phase_next = PH_DATA_SIZE;
                    end
                end
            end
            PH_CHUNK_SIZE: begin
                skip_next = skip_shift;
                pos_next  = pos_inc;
                if (last4) begin
                    pos_next   = '0;
                    phase_next = (skip_shift == '0) ? PH_CHUNK_ID : PH_CHUNK_SKIP;
                end
            end
            PH_CHUNK_SKIP, PH_FMT_EXTRA, PH_DATA_SKIP: begin
                skip_next = skip_dec;
                if (skip_dec == '0) begin
                    phase_next = (phase_reg == PH_CHUNK_SKIP) ? PH_CHUNK_ID : PH_DATA_ID;
                end
            end
            PH_FMT_SIZE: begin
                skip_next = skip_shift;
                pos_next  = pos_inc;
                if (last4) begin
                    pos_next   = '0;
                    phase_next = PH_FMT_TAG;
                end
            end
            PH_FMT_TAG: begin
                tag_next = {file_byte, tag_reg[15:8]};
                pos_next = pos_inc;
                if (pos_inc >= 3'd2) begin
                    pos_next   = '0;
                    phase_next = PH_FMT_CHAN;
                end
            end
            PH_FMT_CHAN: begin
                if (pos_reg == 3'd0) begin
                    gather_next = {24'd0, file_byte};
                end else begin
                    gather_next = gather_reg | {16'd0, file_byte, 8'd0};
                end
                pos_next = pos_inc;
                if (pos_inc >= 3'd2) begin
                    pos_next    = '0;
                    stereo_next = (gather_next == 32'd2);
                    phase_next  = PH_FMT_RATE;
                end
            end
            PH_FMT_RATE: begin
                rate_next = {file_byte, rate_reg[31:8]};
                pos_next  = pos_inc;
                if (last4) begin
                    pos_next   = '0;
                    phase_next = PH_FMT_MISC;
                end
            end
            PH_FMT_MISC: begin
                pos_next = pos_inc;
                if (pos_inc >= 3'd6) begin
                    pos_next   = '0;
                    phase_next = PH_FMT_BITS;
                end
            end
            PH_FMT_BITS: begin
                if (pos_reg == 3'd0) begin
                    gather_next = {8'd0, file_byte, gather_reg[15:0]};
                end else begin
                    gather_next = gather_reg | {file_byte, 24'd0};
                end
                pos_next = pos_inc;
                if (pos_inc >= 3'd2) begin
                    pos_next = '0;
                    emit     = 1'b1;
                    ev.kind  = KIND_ERROR;
                    if (tag_reg != 16'd1) begin
                        ev.error_code = ERR_COMPRESSED;
                    end else if (chans != 16'd1 && chans != 16'd2) begin
                        ev.error_code = ERR_CHANNELS;
                    end else if (bits != 16'd16 && bits != 16'd24) begin
                        ev.error_code = ERR_BITS;
                    end else if (skip_reg < 32'd16) begin
                        ev.error_code = ERR_SHORT_FMT;
                    end else begin
                        emit      = 1'b0;
                        ev        = '0;
                        wide_next = (bits == 16'd24);
                        skip_next = skip_reg - 32'd16;
                        phase_next = (skip_next == '0) ? PH_DATA_ID : PH_FMT_EXTRA;
                    end
                    if (emit) phase_next = PH_HALTED;
                end
            end
            PH_DATA_SIZE: begin
                skip_next = skip_shift;
                mod3_next = mod3_sum;
                pos_next  = pos_inc;
                if (last4) begin
                    pos_next = '0;
                    if (gather_reg != ID_DATA) begin
                        phase_next = (skip_shift == '0) ? PH_DATA_ID : PH_DATA_SKIP;
                    end else if (mod_bad) begin
                        emit          = 1'b1;
                        ev.kind       = KIND_ERROR;
                        ev.error_code = ERR_MULTIPLE;
                        phase_next    = PH_HALTED;
                    end else if (too_long) begin
                        emit          = 1'b1;
                        ev.kind       = KIND_ERROR;
                        ev.error_code = ERR_TOO_LONG;
                        phase_next    = PH_HALTED;
                    end else begin
                        // skip_reg now counts data bytes left
                        emit       = 1'b1;
                        ev.kind    = KIND_REPORT;
                        ev.stereo  = stereo_reg;
                        ev.wide    = wide_reg;
                        ev.word_a  = rate_reg;
                        ev.word_b  = halved;
                        phase_next = (skip_shift == '0) ? PH_HALTED : PH_SAMPLES;
                    end
                end
            end
            PH_SAMPLES: begin
                pos_next  = pos_inc;
                skip_next = skip_dec;
                if (q + 3'd2 == chan_bytes) begin
                    gather_next = {24'd0, file_byte};
                end else if (q + 3'd1 == chan_bytes) begin
                    if (stereo_reg && !second) begin
                        left_next = s;
                    end else begin
                        pos_next  = '0;
                        emit      = 1'b1;
                        ev.kind   = KIND_SAMPLE;
                        ev.stereo = stereo_reg;
                        ev.last   = (skip_reg == 32'd1);
                        ev.word_a = {16'd0, stereo_reg ? left_reg : s};
                        ev.word_b = {16'd0, s};
                        if (skip_reg == 32'd1) phase_next = PH_HALTED;
                    end
                end
            end
            PH_HALTED: begin
            end
            default: begin
            end
        endcase

        // end of file: unless parsing has halted, this is a truncation error, then restart
        if (end_of_file) begin
            if (phase_next != PH_HALTED) begin
                emit          = 1'b1;
                ev            = '0;
                ev.kind       = KIND_ERROR;
                ev.error_code = ERR_TRUNCATED;
            end
            phase_next  = PH_HEADER;
            pos_next    = '0;
            gather_next = '0;
            skip_next   = '0;
            tag_next    = '0;
            stereo_next = 1'b0;
            wide_next   = 1'b0;
            rate_next   = '0;
            left_next   = '0;
            mod3_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= '0;
            gather_reg <= '0;
            skip_reg   <= '0;
            tag_reg    <= '0;
            stereo_reg <= 1'b0;
            wide_reg   <= 1'b0;
            rate_reg   <= '0;
            left_reg   <= '0;
            mod3_reg   <= '0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            gather_reg <= gather_next;
            skip_reg   <= skip_next;
            tag_reg    <= tag_next;
            stereo_reg <= stereo_next;
            wide_reg   <= wide_next;
            rate_reg   <= rate_next;
            left_reg   <= left_next;
            mod3_reg   <= mod3_next;
        end
    end

endmodule

### rtl/wsp_queue.sv
module wsp_queue #(
    parameter int DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  wsp_pkg::wsp_event_t push_data,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output wsp_pkg::wsp_event_t head
);
    import wsp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    wsp_event_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)  rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop) count_next = count_reg + 1'b1;
        if (do_pop && !do_push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### rtl/wsp_encode.sv
module wsp_encode (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic                ev_valid,
    output logic                ev_ready,
    input  wsp_pkg::wsp_event_t ev,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_kind,
    output logic signed [15:0]  m_sample_value,
    output logic [7:0]          m_ulaw_code,
    output logic                m_last_sample,
    output logic [1:0]          m_channel_count,
    output logic [4:0]          m_sample_bits,
    output logic [31:0]         m_sample_rate,
    output logic [23:0]         m_frame_count,
    output logic [2:0]          m_error_code
);
    import wsp_pkg::*;

    logic        mode_reg;
    logic        advance;

    logic        s1_valid_reg;
    logic [1:0]  s1_kind_reg;
    logic [2:0]  s1_code_reg;
    logic        s1_last_reg;
    logic        s1_stereo_reg;
    logic        s1_wide_reg;
    logic [31:0] s1_rate_reg;
    logic [15:0] s1_audio_reg;
    logic [23:0] s1_frames_reg;

    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic [15:0] out_sample_reg;
    logic [7:0]  out_ulaw_reg;
    logic        out_last_reg;
    logic [1:0]  out_chan_reg;
    logic [4:0]  out_bits_reg;
    logic [31:0] out_rate_reg;
    logic [23:0] out_frames_reg;
    logic [2:0]  out_code_reg;

    logic [16:0] pair_sum;
    logic [16:0] pair_adj;
    logic [15:0] audio;
    logic [63:0] prod;
    logic [23:0] frames;
    logic        is_sample;
    logic        is_report;

    assign advance  = !out_valid_reg || m_ready;
    assign ev_ready = advance;

    // stereo mean, truncated toward zero
    assign pair_sum = {ev.word_a[15], ev.word_a[15:0]} + {ev.word_b[15], ev.word_b[15:0]};
    assign pair_adj = pair_sum + {16'd0, pair_sum[16]};
    assign audio    = ev.stereo ? pair_adj[16:1] : ev.word_a[15:0];

    // 24-bit: divide by 3 through the reciprocal, else halve
    assign prod   = 64'(ev.word_b) * 64'(RECIP3);
    assign frames = ev.wide ? prod[56:33] : ev.word_b[24:1];

    assign is_sample = (s1_kind_reg == KIND_SAMPLE);
    assign is_report = (s1_kind_reg == KIND_REPORT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= 1'b1;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) mode_reg <= cfg_wdata;
            if (advance) begin
                s1_valid_reg  <= ev_valid;
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_kind_reg   <= ev.kind;
            s1_code_reg   <= ev.error_code;
            s1_last_reg   <= ev.last;
            s1_stereo_reg <= ev.stereo;
            s1_wide_reg   <= ev.wide;
            s1_rate_reg   <= ev.word_a;
            s1_audio_reg  <= audio;
            s1_frames_reg <= frames;

            out_kind_reg   <= s1_kind_reg;
            out_code_reg   <= s1_code_reg;
            out_last_reg   <= s1_last_reg;
            out_sample_reg <= (is_sample && mode_reg) ? s1_audio_reg : 16'd0;
            out_ulaw_reg   <= (is_sample && !mode_reg) ? mulaw_code(s1_audio_reg) : 8'd0;
            out_chan_reg   <= is_report ? (s1_stereo_reg ? 2'd2 : 2'd1) : 2'd0;
            out_bits_reg   <= is_report ? (s1_wide_reg ? 5'd24 : 5'd16) : 5'd0;
            out_rate_reg   <= is_report ? s1_rate_reg : 32'd0;
            out_frames_reg <= is_report ? s1_frames_reg : 24'd0;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_kind          = out_kind_reg;
    assign m_sample_value  = out_sample_reg;
    assign m_ulaw_code     = out_ulaw_reg;
    assign m_last_sample   = out_last_reg;
    assign m_channel_count = out_chan_reg;
    assign m_sample_bits   = out_bits_reg;
    assign m_sample_rate   = out_rate_reg;
    assign m_frame_count   = out_frames_reg;
    assign m_error_code    = out_code_reg;

endmodule

### rtl/wav_stream_to_pcm_or_ulaw.sv
// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  s_file_byte, s_end_of_file
// m_        out        m_valid / m_ready  kind, sample, mu-law, format report, error code
// cfg_      in         cfg_we             cfg_wdata (output mode, 1 = pcm)
//
// one byte per cycle while s_ready is high; each event passes through the event queue and then
// the two back stages (stereo mean and frame divide, then mu-law and output register)
// a 2-entry event queue sits between parser and back stages; with m_ready low the
// back stages hold and s_ready drops once the queue is full
// synchronous active-low reset clears parser, queue and pipeline; output mode resets to pcm
module wav_stream_to_pcm_or_ulaw #(
    parameter int QUEUE_DEPTH = wsp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_file_byte,
    input  logic               s_end_of_file,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_kind,
    output logic signed [15:0] m_sample_value,
    output logic [7:0]         m_ulaw_code,
    output logic               m_last_sample,
    output logic [1:0]         m_channel_count,
    output logic [4:0]         m_sample_bits,
    output logic [31:0]        m_sample_rate,
    output logic [23:0]        m_frame_count,
    output logic [2:0]         m_error_code
);
    import wsp_pkg::*;

    wsp_event_t push_ev;
    wsp_event_t head_ev;
    logic       push;
    logic       full;
    logic       not_empty;
    logic       pop;

    wsp_parse u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_valid  (s_valid),
        .byte_ready  (s_ready),
        .file_byte   (s_file_byte),
        .end_of_file (s_end_of_file),
        .ev_push     (push),
        .ev          (push_ev),
        .queue_full  (full)
    );

    wsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_ev),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head_ev)
    );

    wsp_encode u_encode (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .ev_valid        (not_empty),
        .ev_ready        (pop),
        .ev              (head_ev),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_sample_value  (m_sample_value),
        .m_ulaw_code     (m_ulaw_code),
        .m_last_sample   (m_last_sample),
        .m_channel_count (m_channel_count),
        .m_sample_bits   (m_sample_bits),
        .m_sample_rate   (m_sample_rate),
        .m_frame_count   (m_frame_count),
        .m_error_code    (m_error_code)
    );

endmodule
